// File: sv/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// mcfp_pkg
// Shared types and constants of the motion command frame parser.
// ----------------------------------------------------------------------------
package mcfp_pkg;

  // Byte values with a fixed meaning on the serial stream.
  localparam logic [7:0] SYNC_BYTE    = 8'd255;
  localparam logic [7:0] CMD_FIRST    = 8'd1;
  localparam logic [7:0] CMD_LAST     = 8'd4;
  localparam logic [7:0] ESC_ALL      = 8'd15;
  localparam logic [7:0] RESTORE_BYTE = 8'd255;

  // Move kinds as reported on the result channel.
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_CW    = 2'd1;
  localparam logic [1:0] KIND_CCW   = 2'd2;
  localparam logic [1:0] KIND_RAPID = 2'd3;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_X_SCALE = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_SCALE = 8'd1;
  localparam logic [7:0] X_SCALE_RST = 8'd105;
  localparam logic [7:0] Y_SCALE_RST = 8'd3;

  // Frame queue between the parser and the result stage.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Parser phase.
  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_D1      = 3'd1,
    PH_D2      = 3'd2,
    PH_D3      = 3'd3,
    PH_D4      = 3'd4,
    PH_ESC     = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  // A completed frame with its data bytes already restored.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] end_x_b;
    logic [7:0] end_y_b;
    logic [7:0] ctr_x_b;
    logic [7:0] ctr_y_b;
  } frame_t;

endpackage

// File: sv/mcfp_byte_if.sv
// ----------------------------------------------------------------------------
// mcfp_byte_if
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface mcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/mcfp_move_if.sv
// ----------------------------------------------------------------------------
// mcfp_move_if
// Valid/ready channel carrying one decoded motion command per item.
// ----------------------------------------------------------------------------
interface mcfp_move_if;
  logic        valid;
  logic        ready;
  logic [1:0]  move_kind;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [7:0]  point_count;

  modport source (output valid, output move_kind, output end_x, output end_y,
                  output center_x, output center_y, output point_count,
                  input ready);
  modport sink   (input valid, input move_kind, input end_x, input end_y,
                  input center_x, input center_y, input point_count,
                  output ready);
endinterface

// File: sv/mcfp_cfg_if.sv
// ----------------------------------------------------------------------------
// mcfp_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mcfp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mcfp_pkg::CFG_ADDR_W-1:0] addr;
  logic [7:0]                      wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: sv/mcfp_front.sv
// ----------------------------------------------------------------------------
// mcfp_front
// Byte parser: tracks the frame phase, collects data bytes and pushes each
// completed, escape-restored frame into the frame queue.
// ----------------------------------------------------------------------------
module mcfp_front (
  input  logic              clk,
  input  logic              rst_n,
  mcfp_byte_if.sink         in_ch,
  output mcfp_pkg::frame_t  push_frame,
  output logic              push_valid,
  input  logic              push_ready
);

  mcfp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       field_r [4];
  logic             accept;
  logic             is_sync;
  logic [7:0]       cmd_m1;
  logic [3:0]       esc;

  // Bytes are taken whenever the queue can hold another frame.
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_sync     = (in_ch.rx_byte == mcfp_pkg::SYNC_BYTE);
  assign cmd_m1      = in_ch.rx_byte - mcfp_pkg::CMD_FIRST;

  // Next phase and pending command kind.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    if (accept) begin
      if (is_sync) begin
        phase_nxt = mcfp_pkg::PH_CMD;
      end else begin
        unique case (phase_r)
          mcfp_pkg::PH_CMD: begin
            if (in_ch.rx_byte >= mcfp_pkg::CMD_FIRST &&
                in_ch.rx_byte <= mcfp_pkg::CMD_LAST) begin
              kind_nxt  = cmd_m1[1:0];
              phase_nxt = mcfp_pkg::PH_D1;
            end else begin
              phase_nxt = mcfp_pkg::PH_DISCARD;
            end
          end
          mcfp_pkg::PH_D1: phase_nxt = mcfp_pkg::PH_D2;
          mcfp_pkg::PH_D2: phase_nxt = mcfp_pkg::PH_D3;
          mcfp_pkg::PH_D3: phase_nxt = mcfp_pkg::PH_D4;
          mcfp_pkg::PH_D4: phase_nxt = mcfp_pkg::PH_ESC;
          default:         phase_nxt = mcfp_pkg::PH_DISCARD;
        endcase
      end
    end
  end

  // Frame output: the escape byte completes the frame.
  always_comb begin
    esc        = (in_ch.rx_byte >= mcfp_pkg::ESC_ALL) ? 4'hF : in_ch.rx_byte[3:0];
    push_valid = accept && !is_sync && (phase_r == mcfp_pkg::PH_ESC);
    push_frame.kind    = kind_r;
    push_frame.end_x_b = esc[3] ? mcfp_pkg::RESTORE_BYTE : field_r[0];
    push_frame.end_y_b = esc[2] ? mcfp_pkg::RESTORE_BYTE : field_r[1];
    push_frame.ctr_x_b = esc[1] ? mcfp_pkg::RESTORE_BYTE : field_r[2];
    push_frame.ctr_y_b = esc[0] ? mcfp_pkg::RESTORE_BYTE : field_r[3];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mcfp_pkg::PH_DISCARD;
      kind_r  <= mcfp_pkg::KIND_LINE;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Data byte capture; every frame writes all four before they are used.
  always_ff @(posedge clk) begin
    if (accept && !is_sync) begin
      unique case (phase_r)
        mcfp_pkg::PH_D1: field_r[0] <= in_ch.rx_byte;
        mcfp_pkg::PH_D2: field_r[1] <= in_ch.rx_byte;
        mcfp_pkg::PH_D3: field_r[2] <= in_ch.rx_byte;
        mcfp_pkg::PH_D4: field_r[3] <= in_ch.rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/mcfp_queue.sv
// ----------------------------------------------------------------------------
// mcfp_queue
// Short first-in first-out queue of completed frames between the parser and
// the result stage.
// ----------------------------------------------------------------------------
module mcfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  mcfp_pkg::frame_t  push_frame,
  input  logic              push_valid,
  output logic              push_ready,
  output mcfp_pkg::frame_t  pop_frame,
  output logic              pop_valid,
  input  logic              pop_ready
);

  mcfp_pkg::frame_t                   mem_r [mcfp_pkg::QUEUE_DEPTH];
  logic [mcfp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mcfp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mcfp_pkg::QUEUE_CNT_W-1:0]   count_r, count_nxt;
  logic                               do_push;
  logic                               do_pop;

  localparam logic [mcfp_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
    mcfp_pkg::QUEUE_CNT_W'(mcfp_pkg::QUEUE_DEPTH);
  localparam logic [mcfp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    mcfp_pkg::QUEUE_PTR_W'(mcfp_pkg::QUEUE_DEPTH - 1);

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_frame  = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

// File: sv/mcfp_back.sv
// ----------------------------------------------------------------------------
// mcfp_back
// Result stage: scales the frame bytes, works out the point count against
// the previous end point and holds the result in an output register.
// ----------------------------------------------------------------------------
module mcfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mcfp_pkg::frame_t  pop_frame,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [7:0]        x_scale,
  input  logic [7:0]        y_scale,
  mcfp_move_if.source       out_ch
);

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] end_x_r, end_y_r, ctr_x_r, ctr_y_r;
  logic [7:0]  count_r;
  logic [7:0]  last_x_r, last_y_r;
  logic        take;
  logic        arc;
  logic [7:0]  dx, dy, dmax, count_nxt;
  logic [15:0] end_x_nxt, end_y_nxt, ctr_x_nxt, ctr_y_nxt;

  // A new frame is taken whenever the output register is free or emptying.
  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;

  // Scaling and point count.
  always_comb begin
    arc       = (pop_frame.kind == mcfp_pkg::KIND_CW) ||
                (pop_frame.kind == mcfp_pkg::KIND_CCW);
    end_x_nxt = 16'(pop_frame.end_x_b) * 16'(x_scale);
    end_y_nxt = 16'(pop_frame.end_y_b) * 16'(y_scale);
    ctr_x_nxt = arc ? 16'(pop_frame.ctr_x_b) * 16'(x_scale) : 16'd0;
    ctr_y_nxt = arc ? 16'(pop_frame.ctr_y_b) * 16'(y_scale) : 16'd0;
    dx = (pop_frame.end_x_b > last_x_r) ? pop_frame.end_x_b - last_x_r
                                        : last_x_r - pop_frame.end_x_b;
    dy = (pop_frame.end_y_b > last_y_r) ? pop_frame.end_y_b - last_y_r
                                        : last_y_r - pop_frame.end_y_b;
    dmax = (dx > dy) ? dx : dy;
    if (arc) begin
      count_nxt = 8'd0;
    end else if (dmax == 8'd0) begin
      count_nxt = 8'd1;
    end else begin
      count_nxt = dmax;
    end
  end

  // Control state: output valid flag and previous end bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_x_r    <= 8'd0;
      last_y_r    <= 8'd0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        last_x_r    <= pop_frame.end_x_b;
        last_y_r    <= pop_frame.end_y_b;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= pop_frame.kind;
      end_x_r <= end_x_nxt;
      end_y_r <= end_y_nxt;
      ctr_x_r <= ctr_x_nxt;
      ctr_y_r <= ctr_y_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.move_kind   = kind_r;
  assign out_ch.end_x       = end_x_r;
  assign out_ch.end_y       = end_y_r;
  assign out_ch.center_x    = ctr_x_r;
  assign out_ch.center_y    = ctr_y_r;
  assign out_ch.point_count = count_r;

endmodule

// File: sv/motion_command_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// motion_command_frame_parser_unit
// Decodes motion command frames from a received byte stream.
//
// The unit takes one received byte per clock cycle on in_ch while the frame
// queue has room and emits one motion command on out_ch for every completed
// frame (sync 255, command 1..4, four data bytes, escape byte). The frame is
// written into a two-entry frame queue when its escape byte is accepted,
// then moves into the output register that presents its result on out_ch.
// The input only stalls when both queue entries hold frames that the output
// side has not yet taken. Register 0 is the x scale (reset 105) and register 1
// the y scale (reset 3); writes to other indices are ignored, and the scales
// should only be changed while no frame is in flight. There is no start-up
// clearing pass.
// ----------------------------------------------------------------------------
module motion_command_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  mcfp_byte_if.sink   in_ch,
  mcfp_move_if.source out_ch,
  mcfp_cfg_if.sink    cfg_ch
);

  logic [7:0]       x_scale_r;
  logic [7:0]       y_scale_r;
  mcfp_pkg::frame_t push_frame, pop_frame;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;

  // Configuration registers; the write channel is always ready.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r <= mcfp_pkg::X_SCALE_RST;
      y_scale_r <= mcfp_pkg::Y_SCALE_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == mcfp_pkg::REG_X_SCALE) begin
        x_scale_r <= cfg_ch.wdata;
      end else if (cfg_ch.addr == mcfp_pkg::REG_Y_SCALE) begin
        y_scale_r <= cfg_ch.wdata;
      end
    end
  end

  // Parser front end.
  mcfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_frame (push_frame),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Frame queue.
  mcfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_frame (push_frame),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_frame  (pop_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Result stage.
  mcfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_frame (pop_frame),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .x_scale   (x_scale_r),
    .y_scale   (y_scale_r),
    .out_ch    (out_ch)
  );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motion command frame parser unit.
//
// Received bytes go in one item at a time. A predictor in the bench follows
// the frame phases, the escape restore and the point count, and queues the
// decoded move that each completed frame should give. Every move taken from
// the unit is checked field by field against the oldest queued move. Both
// sides idle at random, and one stretch runs with no idling at all. The scales
// are changed between phases, only once the unit has drained.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Bench constants.
  localparam int unsigned IDLE_PERCENT = 11;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [mcfp_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [mcfp_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 8'd255;

  // One decoded move as the unit reports it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  point_count;
  } move_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: scales, frame phase and the bytes of the frame in progress.
  logic [7:0]        x_scale_q = mcfp_pkg::X_SCALE_RST;
  logic [7:0]        y_scale_q = mcfp_pkg::Y_SCALE_RST;
  mcfp_pkg::phase_t  rx_phase = mcfp_pkg::PH_DISCARD;
  logic [1:0]        frame_kind = mcfp_pkg::KIND_LINE;
  logic [7:0]        frame_bytes [4];
  logic [7:0]        prev_end_x_b = 8'd0;
  logic [7:0]        prev_end_y_b = 8'd0;
  move_t             pending_moves [$];

  mcfp_byte_if in_ch ();
  mcfp_move_if out_ch ();
  mcfp_cfg_if  cfg_ch ();

  motion_command_frame_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // The result side stalls at random unless the bench is in a steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Steps the predictor by one accepted byte and queues any completed move.
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [3:0] esc;
    logic       arc;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] count;
    move_t      mv;
    if (b == mcfp_pkg::SYNC_BYTE) begin
      rx_phase = mcfp_pkg::PH_CMD;
      return;
    end
    case (rx_phase)
      mcfp_pkg::PH_CMD: begin
        if (b >= mcfp_pkg::CMD_FIRST && b <= mcfp_pkg::CMD_LAST) begin
          frame_kind = 2'(b - mcfp_pkg::CMD_FIRST);
          rx_phase = mcfp_pkg::PH_D1;
        end else begin
          rx_phase = mcfp_pkg::PH_DISCARD;
        end
      end
      mcfp_pkg::PH_D1, mcfp_pkg::PH_D2, mcfp_pkg::PH_D3, mcfp_pkg::PH_D4: begin
        frame_bytes[int'(rx_phase) - int'(mcfp_pkg::PH_D1)] = b;
        rx_phase = mcfp_pkg::phase_t'(rx_phase + 3'd1);
      end
      mcfp_pkg::PH_ESC: begin
        rx_phase = mcfp_pkg::PH_DISCARD;
        esc = (b >= mcfp_pkg::ESC_ALL) ? 4'hF : b[3:0];
        if (esc[3]) frame_bytes[0] = mcfp_pkg::RESTORE_BYTE;
        if (esc[2]) frame_bytes[1] = mcfp_pkg::RESTORE_BYTE;
        if (esc[1]) frame_bytes[2] = mcfp_pkg::RESTORE_BYTE;
        if (esc[0]) frame_bytes[3] = mcfp_pkg::RESTORE_BYTE;
        arc = (frame_kind == mcfp_pkg::KIND_CW) || (frame_kind == mcfp_pkg::KIND_CCW);
        dx = (frame_bytes[0] > prev_end_x_b) ? frame_bytes[0] - prev_end_x_b
                                              : prev_end_x_b - frame_bytes[0];
        dy = (frame_bytes[1] > prev_end_y_b) ? frame_bytes[1] - prev_end_y_b
                                              : prev_end_y_b - frame_bytes[1];
        count = (dx > dy) ? dx : dy;
        if (count == 8'd0) count = 8'd1;
        mv.kind        = frame_kind;
        mv.end_x       = 16'(frame_bytes[0]) * 16'(x_scale_q);
        mv.end_y       = 16'(frame_bytes[1]) * 16'(y_scale_q);
        mv.center_x    = arc ? 16'(frame_bytes[2]) * 16'(x_scale_q) : 16'd0;
        mv.center_y    = arc ? 16'(frame_bytes[3]) * 16'(y_scale_q) : 16'd0;
        mv.point_count = arc ? 8'd0 : count;
        pending_moves.push_back(mv);
        prev_end_x_b = frame_bytes[0];
        prev_end_y_b = frame_bytes[1];
      end
      default: ;
    endcase
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Checks every move taken from the unit against the oldest queued one.
  always @(posedge clk) begin
    move_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_moves.size() == 0) begin
        report_mismatch("move with none expected", out_ch.move_kind, -1);
      end else begin
        want = pending_moves.pop_front();
        if (out_ch.move_kind != want.kind)
          report_mismatch("move_kind", out_ch.move_kind, want.kind);
        if (out_ch.end_x != want.end_x)
          report_mismatch("end_x", out_ch.end_x, want.end_x);
        if (out_ch.end_y != want.end_y)
          report_mismatch("end_y", out_ch.end_y, want.end_y);
        if (out_ch.center_x != want.center_x)
          report_mismatch("center_x", out_ch.center_x, want.center_x);
        if (out_ch.center_y != want.center_y)
          report_mismatch("center_y", out_ch.center_y, want.center_y);
        if (out_ch.point_count != want.point_count)
          report_mismatch("point_count", out_ch.point_count, want.point_count);
      end
    end
  end

  // Ends the run when no item has moved on any channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sends one byte. Called at a falling edge; returns at a falling edge with
  // valid still high, so the next item can follow without a gap.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_rx_byte(b);
    @(negedge clk);
  endtask

  // Stops sending, waits for every queued move and lets the pipeline settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_moves.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes one configuration register while the unit is idle.
  task automatic write_register(input logic [mcfp_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == mcfp_pkg::REG_X_SCALE) x_scale_q = value;
    else if (idx == mcfp_pkg::REG_Y_SCALE) y_scale_q = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Picks a data byte: mostly random, sometimes close to the last end point
  // for short segments, and now and then a sync that breaks the frame.
  function automatic logic [7:0] pick_data_byte(input int pos);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return mcfp_pkg::SYNC_BYTE;
    if (roll < 20 && pos == 0) return 8'(prev_end_x_b + $urandom_range(0, 2));
    if (roll < 20 && pos == 1) return 8'(prev_end_y_b + $urandom_range(0, 2));
    return 8'($urandom_range(0, 254));
  endfunction

  // Sends one frame with random content, mostly well formed.
  task automatic send_random_frame(output int unsigned count);
    int unsigned roll;
    logic [7:0]  cmd;
    logic [7:0]  esc;
    count = 0;
    send_byte(mcfp_pkg::SYNC_BYTE);
    roll = $urandom_range(99);
    if (roll < 90) cmd = 8'($urandom_range(mcfp_pkg::CMD_FIRST, mcfp_pkg::CMD_LAST));
    else if (roll < 94) cmd = 8'd0;
    else cmd = 8'($urandom_range(mcfp_pkg::CMD_LAST + 1, 254));
    send_byte(cmd);
    count = 2;
    if (cmd < mcfp_pkg::CMD_FIRST || cmd > mcfp_pkg::CMD_LAST) return;
    for (int i = 0; i < 4; i++) begin
      send_byte(pick_data_byte(i));
      count++;
    end
    roll = $urandom_range(99);
    if (roll < 60) esc = 8'($urandom_range(0, mcfp_pkg::ESC_ALL - 1));
    else if (roll < 75) esc = 8'd0;
    else if (roll < 95) esc = 8'($urandom_range(mcfp_pkg::ESC_ALL, 254));
    else esc = mcfp_pkg::SYNC_BYTE;
    send_byte(esc);
    count++;
  endtask

  // Random frames with the odd burst of noise between them.
  task automatic run_random_items(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 6) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      send_random_frame(n);
      sent += n;
    end
    drain();
  endtask

  // Bytes before the first sync after reset are thrown away.
  task automatic test_discard_before_sync;
    send_byte(8'd2);
    send_byte(mcfp_pkg::CMD_FIRST);
    drain();
  endtask

  // A line from the origin to itself, and a clockwise arc fully restored by
  // an escape byte above the bit-mask range.
  task automatic test_frame_kinds;
    send_byte(mcfp_pkg::SYNC_BYTE);
    send_byte(8'd1);
    send_byte(8'd0);
    send_byte(8'd0);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'd0);
    send_byte(mcfp_pkg::SYNC_BYTE);
    send_byte(8'd2);
    send_byte(8'd254);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'd200);
    drain();
  endtask

  // A sync inside the data bytes restarts the frame, a sync in place of the
  // escape byte aborts it, and an unknown command discards what follows.
  task automatic test_resync_and_bad_command;
    send_byte(mcfp_pkg::SYNC_BYTE);
    send_byte(8'd4);
    send_byte(8'h12);
    send_byte(mcfp_pkg::SYNC_BYTE);
    send_byte(8'd3);
    send_byte(8'h13);
    send_byte(8'h24);
    send_byte(8'h35);
    send_byte(8'h46);
    send_byte(mcfp_pkg::SYNC_BYTE);
    send_byte(8'd0);
    drain();
  endtask

  // Random traffic under a range of scale settings, extremes included.
  task automatic test_scale_settings;
    run_random_items(250);
    write_register(mcfp_pkg::REG_X_SCALE, 8'd255);
    write_register(mcfp_pkg::REG_Y_SCALE, 8'd255);
    run_random_items(250);
    write_register(mcfp_pkg::REG_X_SCALE, 8'd0);
    write_register(mcfp_pkg::REG_Y_SCALE, 8'd0);
    run_random_items(200);
    write_register(mcfp_pkg::REG_X_SCALE, 8'd1);
    write_register(mcfp_pkg::REG_Y_SCALE, 8'd255);
    run_random_items(200);
    write_register(mcfp_pkg::REG_X_SCALE, 8'($urandom));
    write_register(mcfp_pkg::REG_Y_SCALE, 8'($urandom));
    run_random_items(250);
  endtask

  // Writes to indices beyond the map leave both scales alone.
  task automatic test_unmapped_register;
    write_register(REG_UNMAPPED_LO, 8'd17);
    write_register(REG_UNMAPPED_HI, 8'd200);
    run_random_items(200);
  endtask

  // A long stretch with neither side idling.
  task automatic test_back_to_back;
    write_register(mcfp_pkg::REG_X_SCALE, 8'($urandom));
    write_register(mcfp_pkg::REG_Y_SCALE, 8'($urandom));
    steady = 1'b1;
    run_random_items(350);
    steady = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = mcfp_pkg::REG_X_SCALE;
    cfg_ch.wdata  = 8'd0;
    for (int i = 0; i < 4; i++) frame_bytes[i] = 8'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_discard_before_sync();
    test_frame_kinds();
    test_resync_and_bad_command();
    test_scale_settings();
    test_unmapped_register();
    test_back_to_back();

    drain();
    if (mismatches == 0 && pending_moves.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: motion_command_frame_parser_unit.f
sv/mcfp_pkg.sv
sv/mcfp_byte_if.sv
sv/mcfp_move_if.sv
sv/mcfp_cfg_if.sv
sv/mcfp_front.sv
sv/mcfp_queue.sv
sv/mcfp_back.sv
sv/motion_command_frame_parser_unit.sv
test/testbench.sv
